// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, ignored while reset is asserted (active-low reset)
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked property, checked during reset as well
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/spad_pkg.sv =====
// ----------------------------------------------------------------------------
// spad_pkg
// Types and constants for the speed auto-pause debouncer.
// ----------------------------------------------------------------------------
package spad_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_HYST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_DELAY  = 3'd4;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PAUSE  = 2'd1;
    localparam logic [1:0] ACT_RESUME = 2'd2;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;

    localparam logic [15:0] SPEED_MAX = 16'hFFFF;

    typedef struct packed {
        logic        enable;
        logic [15:0] pause_threshold;
        logic [15:0] resume_hysteresis;
        logic [31:0] pause_delay_ms;
        logic [31:0] resume_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic        auto_paused;
        logic [1:0]  ride_mode;
        logic        fix_valid;
        logic [15:0] speed;
        logic [31:0] now_ms;
    } t_item;

endpackage

// ===== hw/rtl/spad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spad_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module spad_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spad_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spad_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output spad_pkg::t_cfg                    o_cfg
);

    spad_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable            <= 1'b0;
            r_cfg.pause_threshold   <= 16'd300;
            r_cfg.resume_hysteresis <= 16'd200;
            r_cfg.pause_delay_ms    <= 32'd3000;
            r_cfg.resume_delay_ms   <= 32'd2000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spad_pkg::REG_ENABLE:       r_cfg.enable            <= i_cfg_wdata[0];
                spad_pkg::REG_PAUSE_THR:    r_cfg.pause_threshold   <= i_cfg_wdata[15:0];
                spad_pkg::REG_RESUME_HYST:  r_cfg.resume_hysteresis <= i_cfg_wdata[15:0];
                spad_pkg::REG_PAUSE_DELAY:  r_cfg.pause_delay_ms    <= i_cfg_wdata[31:0];
                spad_pkg::REG_RESUME_DELAY: r_cfg.resume_delay_ms   <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/spad_core.sv =====
// ----------------------------------------------------------------------------
// spad_core
// Debounce timers and the pause/resume decision for one report per cycle in which i_adv is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spad_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  spad_pkg::t_cfg  i_cfg,
    input  spad_pkg::t_item i_item,
    output logic [1:0]      o_action
);

    logic        r_low_timing;
    logic [31:0] r_low_start;
    logic        r_high_timing;
    logic [31:0] r_high_start;

    logic        n_low_timing;
    logic [31:0] n_low_start;
    logic        n_high_timing;
    logic [31:0] n_high_start;

    logic [16:0] thr_sum;
    logic [15:0] resume_thr;
    logic [31:0] low_elapsed;
    logic [31:0] high_elapsed;

    assign thr_sum      = {1'b0, i_cfg.pause_threshold} + {1'b0, i_cfg.resume_hysteresis};
    assign resume_thr   = thr_sum[16] ? spad_pkg::SPEED_MAX : thr_sum[15:0];
    assign low_elapsed  = i_item.now_ms - r_low_start;
    assign high_elapsed = i_item.now_ms - r_high_start;

    always_comb begin
        n_low_timing  = r_low_timing;
        n_low_start   = r_low_start;
        n_high_timing = r_high_timing;
        n_high_start  = r_high_start;
        o_action      = spad_pkg::ACT_NONE;

        if (!i_cfg.enable) begin
            n_low_timing  = 1'b0;
            n_low_start   = '0;
            n_high_timing = 1'b0;
            n_high_start  = '0;
            o_action      = i_item.auto_paused ? spad_pkg::ACT_RESUME : spad_pkg::ACT_NONE;
        end else if (i_item.ride_mode == spad_pkg::MODE_STOPPED || !i_item.fix_valid) begin
            n_low_timing  = 1'b0;
            n_low_start   = '0;
            n_high_timing = 1'b0;
            n_high_start  = '0;
        end else if (i_item.ride_mode == spad_pkg::MODE_RUNNING && !i_item.auto_paused) begin
            n_high_timing = 1'b0;
            if (i_item.speed <= i_cfg.pause_threshold) begin
                if (!r_low_timing) begin
                    n_low_timing = 1'b1;
                    n_low_start  = i_item.now_ms;
                end else if (low_elapsed >= i_cfg.pause_delay_ms) begin
                    n_low_timing  = 1'b0;
                    n_low_start   = '0;
                    n_high_start  = '0;
                    o_action      = spad_pkg::ACT_PAUSE;
                end
            end else begin
                n_low_timing = 1'b0;
            end
        end else begin
            n_low_timing = 1'b0;
            if (i_item.ride_mode != spad_pkg::MODE_PAUSED || !i_item.auto_paused) begin
                n_high_timing = 1'b0;
            end else if (i_item.speed >= resume_thr) begin
                if (!r_high_timing) begin
                    n_high_timing = 1'b1;
                    n_high_start  = i_item.now_ms;
                end else if (high_elapsed >= i_cfg.resume_delay_ms) begin
                    n_high_timing = 1'b0;
                    n_low_start   = '0;
                    n_high_start  = '0;
                    o_action      = spad_pkg::ACT_RESUME;
                end
            end else begin
                n_high_timing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_timing  <= 1'b0;
            r_low_start   <= '0;
            r_high_timing <= 1'b0;
            r_high_start  <= '0;
        end else if (i_adv) begin
            r_low_timing  <= n_low_timing;
            r_low_start   <= n_low_start;
            r_high_timing <= n_high_timing;
            r_high_start  <= n_high_start;
        end
    end

    // Only one debounce timer can be armed at a time
    `ASSERT_CLK(a_one_timer, i_clk, i_rst_n, !(r_low_timing && r_high_timing))
    // A fired action disarms both timers
    `ASSERT_CLK(a_fire_clears, i_clk, i_rst_n,
        (i_adv && o_action != spad_pkg::ACT_NONE) |=> (!r_low_timing && !r_high_timing))
    // Disabled processing leaves nothing armed
    `ASSERT_CLK(a_disable_clears, i_clk, i_rst_n,
        (i_adv && !i_cfg.enable) |=> (!r_low_timing && !r_high_timing))

endmodule

// ===== hw/rtl/speed_auto_pause_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// speed_auto_pause_debouncer_unit
// Auto-pause debouncer: turns speed reports into pause/resume requests.
// ----------------------------------------------------------------------------
// Takes one speed report per clock unless the result side stalls, and returns
// exactly one action per report (none, pause or resume), in order. Throughput
// is one report per cycle while the receiver keeps up; a result is valid once
// its report has passed the input register, where the decision is made, and
// has landed in the result register. The cycle is set by the
// decision path: a 32-bit elapsed-time subtraction and compare against the
// programmed delay. Timer state is updated as each report leaves the input
// register, so back-to-back reports see the state left by the one before.
// Configuration is a plain write port; write only while the unit is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module speed_auto_pause_debouncer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spad_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_auto_paused,
    input  logic [1:0]                      i_ride_mode,
    input  logic                            i_fix_valid,
    input  logic [15:0]                     i_speed,
    input  logic [31:0]                     i_now_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_action
);

    spad_pkg::t_cfg  cfg;
    spad_pkg::t_item r_item;
    logic            r_in_valid;
    logic            r_out_valid;
    logic [1:0]      r_action;
    logic [1:0]      core_action;
    logic            adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    spad_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    spad_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_action (core_action)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.auto_paused <= i_auto_paused;
            r_item.ride_mode   <= i_ride_mode;
            r_item.fix_valid   <= i_fix_valid;
            r_item.speed       <= i_speed;
            r_item.now_ms      <= i_now_ms;
        end
        if (adv) begin
            r_action <= core_action;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;

    // Free result slot always lets a new transfer in
    `ASSERT_CLK(a_ready_when_free, i_clk, i_rst_n, !r_out_valid |-> o_in_ready)
    // Every decision lands in the result register
    `ASSERT_CLK(a_adv_fills_out, i_clk, i_rst_n, adv |=> r_out_valid)
    // A held report is not dropped while the result side stalls
    `ASSERT_CLK(a_hold_item, i_clk, i_rst_n, (r_in_valid && !adv) |=> r_in_valid)

endmodule

// ===== bench/speed_auto_pause_debouncer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// speed_auto_pause_debouncer_unit_tb
// Self-checking bench for the speed auto-pause debouncer.
// ----------------------------------------------------------------------------
// Speed reports go in over a valid/ready channel and every accepted report is
// run through a local model of the pause and resume timers. The model's action
// is queued, and each action transfer from the unit is checked against the
// oldest queued one. A short directed run covers the disabled, stopped and
// no-fix cases, both timers firing, a lost condition, saturation of the resume
// threshold and zero and maximum delays. Random ride episodes follow over
// several register settings. Both sides idle at random, and the receiver
// holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module speed_auto_pause_debouncer_unit_tb;

    localparam logic [1:0]                     MODE_OTHER    = 2'd3;
    localparam logic [spad_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO =
        spad_pkg::REG_RESUME_DELAY + 3'd1;
    localparam int                             N_PHASES      = 8;
    localparam int                             PHASE_REPORTS = 135;

    class action_scoreboard;
        spad_pkg::t_cfg cfg;
        bit             low_timing;
        bit             high_timing;
        logic [31:0]    low_start;
        logic [31:0]    high_start;
        logic [1:0]     expected_actions[$];
        int             mismatches;

        function new();
            cfg.enable            = 1'b0;
            cfg.pause_threshold   = 16'd300;
            cfg.resume_hysteresis = 16'd200;
            cfg.pause_delay_ms    = 32'd3000;
            cfg.resume_delay_ms   = 32'd2000;
            clear_timers();
            mismatches = 0;
        endfunction

        function void clear_timers();
            low_timing  = 1'b0;
            low_start   = '0;
            high_timing = 1'b0;
            high_start  = '0;
        endfunction

        function void write_reg(logic [spad_pkg::CFG_IDX_W-1:0] idx,
                                logic [spad_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spad_pkg::REG_ENABLE:       cfg.enable            = data[0];
                spad_pkg::REG_PAUSE_THR:    cfg.pause_threshold   = data[15:0];
                spad_pkg::REG_RESUME_HYST:  cfg.resume_hysteresis = data[15:0];
                spad_pkg::REG_PAUSE_DELAY:  cfg.pause_delay_ms    = data;
                spad_pkg::REG_RESUME_DELAY: cfg.resume_delay_ms   = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] resume_threshold();
            logic [16:0] thr_sum;
            thr_sum = {1'b0, cfg.pause_threshold} + {1'b0, cfg.resume_hysteresis};
            return thr_sum[16] ? spad_pkg::SPEED_MAX : thr_sum[15:0];
        endfunction

        function logic [1:0] decide_action(spad_pkg::t_item it);
            logic [31:0] elapsed;
            if (!cfg.enable) begin
                clear_timers();
                return it.auto_paused ? spad_pkg::ACT_RESUME : spad_pkg::ACT_NONE;
            end
            if (it.ride_mode == spad_pkg::MODE_STOPPED || !it.fix_valid) begin
                clear_timers();
                return spad_pkg::ACT_NONE;
            end
            if (it.ride_mode == spad_pkg::MODE_RUNNING && !it.auto_paused) begin
                high_timing = 1'b0;
                if (it.speed <= cfg.pause_threshold) begin
                    elapsed = it.now_ms - low_start;
                    if (!low_timing) begin
                        low_timing = 1'b1;
                        low_start  = it.now_ms;
                    end else if (elapsed >= cfg.pause_delay_ms) begin
                        clear_timers();
                        return spad_pkg::ACT_PAUSE;
                    end
                end else begin
                    low_timing = 1'b0;
                end
                return spad_pkg::ACT_NONE;
            end
            low_timing = 1'b0;
            if (it.ride_mode != spad_pkg::MODE_PAUSED || !it.auto_paused) begin
                high_timing = 1'b0;
                return spad_pkg::ACT_NONE;
            end
            if (it.speed >= resume_threshold()) begin
                elapsed = it.now_ms - high_start;
                if (!high_timing) begin
                    high_timing = 1'b1;
                    high_start  = it.now_ms;
                end else if (elapsed >= cfg.resume_delay_ms) begin
                    clear_timers();
                    return spad_pkg::ACT_RESUME;
                end
            end else begin
                high_timing = 1'b0;
            end
            return spad_pkg::ACT_NONE;
        endfunction

        function void note_report(spad_pkg::t_item it);
            expected_actions.push_back(decide_action(it));
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction

        function void check_action(logic [1:0] got);
            logic [1:0] want;
            if (expected_actions.size() == 0) begin
                $display("%0t: unexpected action transfer, expected none, got %0d", $time, got);
                mismatches++;
                return;
            end
            want = expected_actions.pop_front();
            if (got !== want) begin
                $display("%0t: action mismatch, expected %0d, got %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [spad_pkg::CFG_IDX_W-1:0]  cfg_idx       = '0;
    logic [spad_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                            in_valid      = 1'b0;
    logic                            auto_paused   = 1'b0;
    logic [1:0]                      ride_mode     = spad_pkg::MODE_STOPPED;
    logic                            fix_valid     = 1'b0;
    logic [15:0]                     speed         = '0;
    logic [31:0]                     now_ms        = '0;
    logic                            out_ready     = 1'b0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic [1:0]                      o_action;

    action_scoreboard sb;
    int               tx_gap_pct = 20;
    int               rx_gap_pct = 20;
    int               long_hold  = 0;
    int               reports_sent = 0;
    logic [31:0]      ride_ms = '0;

    speed_auto_pause_debouncer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_auto_paused (auto_paused),
        .i_ride_mode   (ride_mode),
        .i_fix_valid   (fix_valid),
        .i_speed       (speed),
        .i_now_ms      (now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_action      (o_action)
    );

    always #6 clk = ~clk;

    task automatic send_report(spad_pkg::t_item it);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        auto_paused <= it.auto_paused;
        ride_mode   <= it.ride_mode;
        fix_valid   <= it.fix_valid;
        speed       <= it.speed;
        now_ms      <= it.now_ms;
        do @(posedge clk); while (!o_in_ready);
        sb.note_report(it);
        reports_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // unused bits of the narrow registers carry noise; one write per phase
    // goes to an unmapped index
    task automatic set_config(spad_pkg::t_cfg c);
        logic [spad_pkg::CFG_IDX_W-1:0]  idx [6];
        logic [spad_pkg::CFG_DATA_W-1:0] val [6];
        idx = '{spad_pkg::REG_ENABLE, spad_pkg::REG_PAUSE_THR, spad_pkg::REG_RESUME_HYST,
                spad_pkg::REG_PAUSE_DELAY, spad_pkg::REG_RESUME_DELAY,
                REG_UNUSED_LO + 3'($urandom_range(0, 2))};
        val = '{{31'($urandom()), c.enable}, {16'($urandom()), c.pause_threshold},
                {16'($urandom()), c.resume_hysteresis}, c.pause_delay_ms,
                c.resume_delay_ms, $urandom()};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 5000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_speed_setting();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return spad_pkg::SPEED_MAX;
            2:       return 16'($urandom_range(100, 1000));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic spad_pkg::t_cfg pick_config(int phase);
        spad_pkg::t_cfg c;
        c.enable            = 1'b1;
        c.pause_threshold   = pick_speed_setting();
        c.resume_hysteresis = pick_speed_setting();
        c.pause_delay_ms    = pick_delay();
        c.resume_delay_ms   = pick_delay();
        if (phase == 0) begin
            c = spad_pkg::t_cfg'{1'b1, spad_pkg::SPEED_MAX, spad_pkg::SPEED_MAX, '1, '1};
        end else if (phase == 1) begin
            c = spad_pkg::t_cfg'{1'b1, '0, '0, '0, '0};
        end else if (phase == 2) begin
            c.enable = 1'b0;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [31:0] time_step(logic [31:0] delay);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return delay;
            2:       return delay - 32'd1;
            3:       return $urandom();
            4:       return $urandom_range(0, 2000);
            default: return $urandom_range(0, delay);
        endcase
    endfunction

    // low-speed running rides, high-speed auto-paused rides, and noise
    task automatic run_episode();
        int              kind;
        int              len;
        spad_pkg::t_item it;
        logic [15:0]     thr;
        logic [15:0]     rthr;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(2, 12);
        thr  = sb.cfg.pause_threshold;
        rthr = sb.resume_threshold();
        for (int k = 0; k < len; k++) begin
            it.fix_valid = ($urandom_range(0, 15) != 0);
            if (kind < 4) begin
                it.auto_paused = 1'b0;
                it.ride_mode   = spad_pkg::MODE_RUNNING;
                case ($urandom_range(0, 7))
                    0:       it.speed = thr;
                    1:       it.speed = thr + 16'd1;
                    2:       it.speed = 16'($urandom());
                    default: it.speed = 16'($urandom_range(0, thr));
                endcase
                ride_ms += time_step(sb.cfg.pause_delay_ms);
            end else if (kind < 8) begin
                it.auto_paused = 1'b1;
                it.ride_mode   = spad_pkg::MODE_PAUSED;
                case ($urandom_range(0, 7))
                    0:       it.speed = rthr;
                    1:       it.speed = rthr - 16'd1;
                    2:       it.speed = 16'($urandom());
                    default: it.speed = 16'($urandom_range(rthr, spad_pkg::SPEED_MAX));
                endcase
                ride_ms += time_step(sb.cfg.resume_delay_ms);
            end else begin
                it.auto_paused = 1'($urandom());
                it.ride_mode   = 2'($urandom());
                it.fix_valid   = 1'($urandom());
                it.speed       = 16'($urandom());
                ride_ms        = $urandom();
            end
            if ($urandom_range(0, 19) == 0) begin
                it.auto_paused = 1'($urandom());
                it.ride_mode   = 2'($urandom());
            end
            it.now_ms = ride_ms;
            send_report(it);
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && out_ready) sb.check_action(o_action);
            if (long_hold > 0) begin
                long_hold--;
                out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
                stall = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_800_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int target;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit disabled
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'd500, 32'd0});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd0, 32'd0});
        wait_idle();
        set_config(spad_pkg::t_cfg'{1'b1, 16'd300, 16'd200, 32'd3000, 32'd2000});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_STOPPED, 1'b1, 16'd0, 32'd10});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b0, 16'd0, 32'd20});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd300, 32'd100});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd300, 32'd3099});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd300, 32'd3100});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd0, 32'd5000});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd301, 32'd6000});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd0, 32'd9000});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'd0, 32'd12000});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'd500, 32'd20000});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'd500, 32'd21999});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'd500, 32'd22000});
        send_report(spad_pkg::t_item'{1'b1, MODE_OTHER, 1'b1, 16'd500, 32'd23000});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_RUNNING, 1'b1, 16'd0, 32'd24000});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_PAUSED, 1'b1, 16'd500, 32'd25000});
        wait_idle();
        // saturated resume threshold, zero resume delay, maximum pause delay
        set_config(spad_pkg::t_cfg'{1'b1, spad_pkg::SPEED_MAX, spad_pkg::SPEED_MAX, '1, '0});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'hFFFF, 32'd5});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'hFFFE, 32'd6});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'hFFFF, 32'd7});
        send_report(spad_pkg::t_item'{1'b1, spad_pkg::MODE_PAUSED, 1'b1, 16'hFFFF, 32'd7});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'hFFFF, 32'd1});
        send_report(spad_pkg::t_item'{1'b0, spad_pkg::MODE_RUNNING, 1'b1, 16'hFFFF, 32'd0});

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            set_config(pick_config(p));
            ride_ms    = $urandom();
            tx_gap_pct = pick_gap();
            rx_gap_pct = pick_gap();
            if (p == 3) begin
                tx_gap_pct = 0;
                long_hold  = 150;
            end
            if (p == N_PHASES - 1) begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            target = reports_sent + PHASE_REPORTS;
            while (reports_sent < target) begin
                run_episode();
                if (p == 5 && $urandom_range(0, 9) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
